FILE: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace core
// Record format passed from the classifier to the emitter, register indexes
// and fixed field widths.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int EMIT_MAX   = 8;                      // most bytes one input can cause
   localparam int DATA_W     = EMIT_MAX * BYTE_W;      // 64-bit pattern/replacement words
   localparam int COUNT_W    = 4;                      // 0..EMIT_MAX
   localparam int IDX_W      = 3;                      // 0..EMIT_MAX-1
   localparam int TALLY_W    = 16;
   localparam int LEN_W      = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PATTERN_BYTES  = 4'd0,
      CSR_PATTERN_LENGTH = 4'd1,
      CSR_REPLACE_BYTES  = 4'd2,
      CSR_REPLACE_LENGTH = 4'd3
   } csr_index_type;

   // One classified input word: up to EMIT_MAX bytes to send, in order
   typedef struct packed {
      logic [DATA_W-1:0]  data;     // byte 0 in bits 7..0
      logic [COUNT_W-1:0] cnt;      // bytes to send; zero only on an empty end
      logic               str_end;  // closes the string
      logic [TALLY_W-1:0] tally;    // replacement count including this word
   } rec_type;

endpackage

FILE: hw/rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_req_if / sfr_rsp_if: valid/ready channels of the find/replace core
// Input channel carries source bytes, result channel the rewritten stream.
// ----------------------------------------------------------------------------
interface sfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::BYTE_W-1:0]  in_byte;
   logic                        in_end;

   modport source (output valid, output in_byte, output in_end, input ready);
   modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface sfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::BYTE_W-1:0]  out_byte;
   logic                        byte_valid;
   logic                        run_last;
   logic                        string_done;
   logic [sfr_pkg::TALLY_W-1:0] replace_total;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output string_done, output replace_total, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input string_done, input replace_total, output ready);
endinterface

FILE: hw/rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: window, pattern compare and record build
// Holds the configuration, inserts each input byte into the pending window,
// compares against the pattern and issues one record per word with output.
// ----------------------------------------------------------------------------
module sfr_front #(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   sfr_req_if.sink                          req_if,
   input  logic                             csr_we,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sfr_pkg::DATA_W-1:0]       csr_wdata,
   output logic                             rec_valid,
   input  logic                             rec_ready,
   output sfr_pkg::rec_type                 rec
);

   localparam logic [sfr_pkg::LEN_W-1:0] MAX_P = sfr_pkg::LEN_W'(MAX_PATTERN);
   localparam logic [sfr_pkg::LEN_W-1:0] MAX_R = sfr_pkg::LEN_W'(MAX_REPLACE);
   localparam logic [sfr_pkg::TALLY_W-1:0] TALLY_SAT = '1;

   // configuration
   logic [sfr_pkg::DATA_W-1:0]  pat_ff, rep_ff;
   logic [sfr_pkg::LEN_W-1:0]   plen_ff, rlen_ff;

   // state
   logic [sfr_pkg::BYTE_W-1:0]  win_ff [MAX_PATTERN];
   logic [sfr_pkg::BYTE_W-1:0]  win_in [MAX_PATTERN];
   logic [sfr_pkg::LEN_W-1:0]   fill_ff, fill_in;
   logic [sfr_pkg::TALLY_W-1:0] tally_ff, tally_in;

   logic [sfr_pkg::BYTE_W-1:0]  w_new [MAX_PATTERN];
   logic [sfr_pkg::LEN_W-1:0]   plen, rlen, fillc, fill_next;
   logic [sfr_pkg::TALLY_W-1:0] tally_new;
   logic                        accept, full, hit;

   assign plen = (plen_ff == '0) ? sfr_pkg::LEN_W'(1) : ((plen_ff > MAX_P) ? MAX_P : plen_ff);
   assign rlen = (rlen_ff > MAX_R) ? MAX_R : rlen_ff;

   assign req_if.ready = rec_ready;
   assign accept       = req_if.valid && rec_ready;

   always_comb begin
      fillc = (fill_ff >= plen) ? plen - sfr_pkg::LEN_W'(1) : fill_ff;
      fill_next = fillc + sfr_pkg::LEN_W'(1);
      full = (fill_next == plen);
      hit  = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         w_new[i] = (sfr_pkg::LEN_W'(i) == fillc) ? req_if.in_byte : win_ff[i];
         if (sfr_pkg::LEN_W'(i) < plen &&
             w_new[i] != pat_ff[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]) begin
            hit = 1'b0;
         end
      end
      hit = hit && full;
      tally_new = (hit && tally_ff != TALLY_SAT) ? tally_ff + sfr_pkg::TALLY_W'(1) : tally_ff;

      // record
      rec.data    = '0;
      rec.str_end = req_if.in_end;
      rec.tally   = tally_new;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         rec.data[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = w_new[i];
      end
      if (hit) begin
         rec.data = rep_ff;
         rec.cnt  = rlen;
      end else if (full) begin
         // oldest byte goes out; at end the rest of the window follows it
         rec.cnt = req_if.in_end ? plen : sfr_pkg::COUNT_W'(1);
      end else begin
         rec.cnt = req_if.in_end ? fill_next : '0;
      end
      rec_valid = accept && (rec.cnt != '0 || req_if.in_end);

      // next state
      win_in   = w_new;
      fill_in  = fill_ff;
      tally_in = tally_ff;
      if (accept) begin
         tally_in = tally_new;
         if (hit) begin
            fill_in = '0;
         end else if (full) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
               win_in[i] = w_new[i+1];
            end
            fill_in = plen - sfr_pkg::LEN_W'(1);
         end else begin
            fill_in = fill_next;
         end
         if (req_if.in_end) begin
            fill_in  = '0;
            tally_in = '0;
         end
      end
      if (csr_we && csr_addr == sfr_pkg::CSR_PATTERN_LENGTH) begin
         fill_in  = '0;
         tally_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         tally_ff <= '0;
         pat_ff   <= '0;
         plen_ff  <= sfr_pkg::LEN_W'(1);
         rep_ff   <= '0;
         rlen_ff  <= '0;
      end else begin
         fill_ff  <= fill_in;
         tally_ff <= tally_in;
         if (csr_we) begin
            case (csr_addr)
               sfr_pkg::CSR_PATTERN_BYTES:  pat_ff  <= csr_wdata;
               sfr_pkg::CSR_PATTERN_LENGTH: plen_ff <= csr_wdata[sfr_pkg::LEN_W-1:0];
               sfr_pkg::CSR_REPLACE_BYTES:  rep_ff  <= csr_wdata;
               sfr_pkg::CSR_REPLACE_LENGTH: rlen_ff <= csr_wdata[sfr_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: hw/rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue: two-entry record queue
// Decouples the classifier from the emitter so each may stall on its own.
// ----------------------------------------------------------------------------
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sfr_pkg::rec_type push_rec,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sfr_pkg::rec_type pop_rec
);

   localparam int PTR_W = $clog2(sfr_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

   sfr_pkg::rec_type  mem_ff [sfr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(sfr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_rec    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: record serialiser
// Walks the head record, one byte per unstalled cycle, into a result register.
// ----------------------------------------------------------------------------
module sfr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_valid,
   output logic             rec_pop,
   input  sfr_pkg::rec_type rec,
   sfr_rsp_if.source        rsp_if
);

   logic [sfr_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        vld_ff;
   logic [sfr_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                        bval_ff, last_ff, done_ff;
   logic [sfr_pkg::TALLY_W-1:0] tot_ff;
   logic                        load, last;

   assign load = rec_valid && (!vld_ff || rsp_if.ready);
   assign last = (rec.cnt == '0) ||
                 (sfr_pkg::COUNT_W'(idx_ff) + sfr_pkg::COUNT_W'(1) == rec.cnt);
   assign rec_pop = load && last;

   always_comb begin
      byte_in = rec.data[idx_ff*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
      if (rec.cnt == '0) begin
         byte_in = '0;
      end
      idx_in = idx_ff;
      if (load) begin
         idx_in = last ? '0 : idx_ff + sfr_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         bval_ff <= (rec.cnt != '0);
         last_ff <= last;
         done_ff <= last && rec.str_end;
         tot_ff  <= rec.tally;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            vld_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid         = vld_ff;
   assign rsp_if.out_byte      = byte_ff;
   assign rsp_if.byte_valid    = bval_ff;
   assign rsp_if.run_last      = last_ff;
   assign rsp_if.string_done   = done_ff;
   assign rsp_if.replace_total = tot_ff;

endmodule

FILE: hw/rtl/stream_find_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core: streaming find-and-replace over a byte string
// Classifier, two-record queue and byte serialiser behind valid/ready ports.
// ----------------------------------------------------------------------------
// Takes one source byte a cycle and rewrites the string on the fly: every
// leftmost, non-overlapping occurrence of the pattern (1..MAX_PATTERN bytes)
// becomes the replacement (0..MAX_REPLACE bytes, zero deletes). Each word on
// the result channel carries one byte; run_last closes the results of one
// input word and string_done closes the string, with replace_total giving the
// saturating replacement count. An end word with nothing left to send gives
// one result with byte_valid low. Input bytes enter at one per cycle unless
// req is backpressured. The serialiser sends one registered result per cycle
// while rsp is ready and stays busy until an input word's results are out;
// the two-record queue in front of it backpressures req while a replacement
// or end flush drains, or rsp stalls. Write the registers only while
// the core is idle; writing pattern_length drops pending bytes and the count.
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   sfr_req_if.sink                        req_if,
   sfr_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sfr_pkg::DATA_W-1:0]     csr_wdata
);

   // front to queue
   logic             f_valid, f_ready;
   sfr_pkg::rec_type f_rec;
   // queue to back
   logic             b_valid, b_pop;
   sfr_pkg::rec_type b_rec;

   // window, compare, configuration
   sfr_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_REPLACE (MAX_REPLACE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rec_valid (f_valid),
      .rec_ready (f_ready),
      .rec       (f_rec)
   );

   // decoupling queue
   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_rec   (f_rec),
      .pop_valid  (b_valid),
      .pop_ready  (b_pop),
      .pop_rec    (b_rec)
   );

   // serialiser and result register
   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (b_valid),
      .rec_pop   (b_pop),
      .rec       (b_rec),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTHESIS
   // end of string always closes the run of its input word
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.string_done |-> rsp_if.run_last)
      else $error("string_done without run_last");

   // an empty result only ever closes a string, and carries a zero byte
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.byte_valid |->
         rsp_if.string_done && rsp_if.out_byte == '0)
      else $error("empty result outside end of string");

   // a record with no bytes is only issued for an end word
   a_rec_empty: assert property (@(posedge clock) disable iff (reset)
      f_valid && f_rec.cnt == '0 |-> f_rec.str_end)
      else $error("empty record issued mid-string");
`endif

endmodule

FILE: tb/sv/tb_stream_find_replace_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_find_replace_core: self-checking bench for the find/replace core
// Feeds byte strings through the req channel under random stalls on both
// sides, works out every rsp word from its own copy of the window, the
// registers and the replacement tally, and checks the words in order.
// ----------------------------------------------------------------------------
module tb_stream_find_replace_core;

   localparam int MAX_PATTERN   = 8;
   localparam int MAX_REPLACE   = 8;
   localparam int CLOCK_HALF    = 4;
   localparam int RANDOM_ITEMS  = 440;
   localparam int CALM_ITEMS    = 80;     // closing stretch, no idling either side
   localparam int HOLD_CYCLES   = 60;     // long rsp hold-off, fills the core
   localparam int SETTLE_CYCLES = 4;      // covers the accept-to-result path through queue and result register
   localparam int TAIL_CYCLES   = 16;
   localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
   localparam logic [sfr_pkg::CSR_ADDR_W-1:0] CSR_LAST_INDEX = '1;

   typedef struct packed {
      logic [sfr_pkg::BYTE_W-1:0]  out_byte;
      logic                        byte_valid;
      logic                        run_last;
      logic                        string_done;
      logic [sfr_pkg::TALLY_W-1:0] replace_total;
   } result_word_type;

   // Tracks the core's registers and window; queues the rsp words each
   // accepted byte must cause and checks them as they come out.
   class rewrite_scoreboard_type;
      logic [sfr_pkg::DATA_W-1:0] pattern_word;
      logic [sfr_pkg::DATA_W-1:0] replace_word;
      logic [sfr_pkg::LEN_W-1:0]  pattern_len;
      logic [sfr_pkg::LEN_W-1:0]  replace_len;
      logic [sfr_pkg::BYTE_W-1:0] window [MAX_PATTERN];
      int unsigned                fill;
      int unsigned                tally;
      result_word_type            expected_words [$];
      int unsigned                mismatches;

      function new();
         pattern_word = '0;
         replace_word = '0;
         pattern_len  = sfr_pkg::LEN_W'(1);
         replace_len  = '0;
         foreach (window[k]) window[k] = '0;
         fill       = 0;
         tally      = 0;
         mismatches = 0;
      endfunction

      function int unsigned pattern_span();
         if (pattern_len == 0) return 1;
         if (pattern_len > MAX_PATTERN) return MAX_PATTERN;
         return int'(pattern_len);
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void write_reg(logic [sfr_pkg::CSR_ADDR_W-1:0] idx,
                              logic [sfr_pkg::DATA_W-1:0] value);
         case (idx)
            sfr_pkg::CSR_PATTERN_BYTES:  pattern_word = value;
            sfr_pkg::CSR_PATTERN_LENGTH: begin
               // new length drops pending bytes and the count
               pattern_len = value[sfr_pkg::LEN_W-1:0];
               fill        = 0;
               tally       = 0;
            end
            sfr_pkg::CSR_REPLACE_BYTES:  replace_word = value;
            sfr_pkg::CSR_REPLACE_LENGTH: replace_len = value[sfr_pkg::LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_source_word(logic [sfr_pkg::BYTE_W-1:0] src, logic last_of_string);
         logic [sfr_pkg::BYTE_W-1:0] emitted [sfr_pkg::EMIT_MAX];
         int unsigned                plen, rlen, n, count, k;
         bit                         hit;
         result_word_type            w;

         plen = pattern_span();
         rlen = (replace_len > MAX_REPLACE) ? MAX_REPLACE : int'(replace_len);
         n    = 0;
         if (fill >= plen) fill = plen - 1;
         window[fill] = src;
         fill++;

         if (fill == plen) begin
            hit = 1'b1;
            for (k = 0; k < plen; k++)
               if (window[k] != pattern_word[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W])
                  hit = 1'b0;
            if (hit) begin
               if (tally < 65535) tally++;
               for (k = 0; k < rlen; k++) begin
                  emitted[n] = replace_word[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W];
                  n++;
               end
               fill = 0;
            end else begin
               emitted[n] = window[0];
               n++;
               for (k = 1; k < fill; k++) window[k-1] = window[k];
               fill--;
            end
         end

         if (last_of_string) begin
            for (k = 0; k < fill; k++) begin
               emitted[n] = window[k];
               n++;
            end
            fill = 0;
         end

         // an end with nothing left still closes the string with one empty word
         count = (last_of_string && n == 0) ? 1 : n;
         for (k = 0; k < count; k++) begin
            w.out_byte      = (n == 0) ? '0 : emitted[k];
            w.byte_valid    = (n != 0);
            w.run_last      = (k == count - 1);
            w.string_done   = (k == count - 1) && last_of_string;
            w.replace_total = sfr_pkg::TALLY_W'(tally);
            expected_words.push_back(w);
         end
         if (last_of_string) tally = 0;
      endfunction

      function void compare_field(string field, logic [sfr_pkg::TALLY_W-1:0] want,
                                  logic [sfr_pkg::TALLY_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result_word(result_word_type got);
         result_word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected rsp word, actual byte %0h valid %0b last %0b done %0b",
                     $time, got.out_byte, got.byte_valid, got.run_last, got.string_done);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("out_byte", sfr_pkg::TALLY_W'(want.out_byte),
                       sfr_pkg::TALLY_W'(got.out_byte));
         compare_field("byte_valid", sfr_pkg::TALLY_W'(want.byte_valid),
                       sfr_pkg::TALLY_W'(got.byte_valid));
         compare_field("run_last", sfr_pkg::TALLY_W'(want.run_last),
                       sfr_pkg::TALLY_W'(got.run_last));
         compare_field("string_done", sfr_pkg::TALLY_W'(want.string_done),
                       sfr_pkg::TALLY_W'(got.string_done));
         compare_field("replace_total", want.replace_total, got.replace_total);
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [sfr_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [sfr_pkg::DATA_W-1:0]     csr_wdata;
   bit                             calm = 1'b0;          // closing stretch: no idling
   bit                             hold_request = 1'b0;  // asks the sink for a long hold-off
   logic [sfr_pkg::BYTE_W-1:0]     text_q [$];           // string being sent
   rewrite_scoreboard_type         sb;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();

   stream_find_replace_core #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_REPLACE (MAX_REPLACE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Both channels sampled at the edge, before any of this edge's updates land.
   // Inputs are noted first so a same-edge result would still find its word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_source_word(req_bus.in_byte, req_bus.in_end);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result_word(result_word_type'({rsp_bus.out_byte, rsp_bus.byte_valid,
                                                    rsp_bus.run_last, rsp_bus.string_done,
                                                    rsp_bus.replace_total}));
      end
   end

   // Watchdog: too long with no word moving on either channel ends the run.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Result sink: random ready bursts, one long hold-off on request.
   initial begin : result_sink
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Offers one word and returns at the edge that takes it; valid stays high.
   task automatic send_word(input logic [sfr_pkg::BYTE_W-1:0] src, input logic last_of_string);
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= src;
      req_bus.in_end  <= last_of_string;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_text(input bit with_end, input bit gappy);
      foreach (text_q[k]) begin
         send_word(text_q[k], with_end && (k == text_q.size() - 1));
         if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Whole pattern copies for half the pieces, else broken prefixes, runs of the
   // leading byte (overlap traps) and loose bytes.
   task automatic compose_text();
      int unsigned span, pieces, cut, k;
      span = sb.pattern_span();
      text_q.delete();
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
         case ($urandom_range(0, 5))
            0, 1, 2: for (k = 0; k < span; k++)
               text_q.push_back(sb.pattern_word[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W]);
            3: begin
               cut = (span > 1) ? $urandom_range(1, span - 1) : 1;
               for (k = 0; k < cut; k++)
                  text_q.push_back(sb.pattern_word[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W]);
               text_q.push_back(sfr_pkg::BYTE_W'($urandom));
            end
            4: repeat ($urandom_range(1, 4)) begin
               k = $urandom_range(0, sfr_pkg::EMIT_MAX - 1);
               if ($urandom_range(0, 1))
                  text_q.push_back(sb.pattern_word[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W]);
               else
                  text_q.push_back(sfr_pkg::BYTE_W'($urandom));
            end
            default: repeat ($urandom_range(1, 4))
               text_q.push_back(sb.pattern_word[sfr_pkg::BYTE_W-1:0]);
         endcase
      end
   endtask

   task automatic put_reg(input logic [sfr_pkg::CSR_ADDR_W-1:0] idx,
                          input logic [sfr_pkg::DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Idle the source and let every expected word out, plus the core's latency.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Length registers carry random upper bits, which the core must mask off.
   task automatic load_settings(input logic [sfr_pkg::LEN_W-1:0] plen,
                                input logic [sfr_pkg::DATA_W-1:0] pat,
                                input logic [sfr_pkg::LEN_W-1:0] rlen,
                                input logic [sfr_pkg::DATA_W-1:0] rep,
                                input bit with_length);
      logic [sfr_pkg::DATA_W-1:0] noise;
      wait_for_drain();
      noise = {$urandom, $urandom};
      put_reg(sfr_pkg::CSR_PATTERN_BYTES, pat);
      if (with_length)
         put_reg(sfr_pkg::CSR_PATTERN_LENGTH, {noise[sfr_pkg::DATA_W-1:sfr_pkg::LEN_W], plen});
      put_reg(sfr_pkg::CSR_REPLACE_BYTES, rep);
      put_reg(sfr_pkg::CSR_REPLACE_LENGTH,
              {noise[sfr_pkg::LEN_W +: sfr_pkg::DATA_W-sfr_pkg::LEN_W], rlen});
   endtask

   initial begin : stimulus
      logic [sfr_pkg::DATA_W-1:0] pat, rep;
      logic [sfr_pkg::LEN_W-1:0]  plen, rlen;
      logic [sfr_pkg::BYTE_W-1:0] pick_a, pick_b;
      int unsigned                random_items, phase, strings, k;

      sb = new();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= '0;
      req_bus.in_end  <= 1'b0;
      csr_we          <= 1'b0;
      csr_addr        <= '0;
      csr_wdata       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: one-byte pattern 00, empty replacement.
      send_word(8'h00, 1'b0);   // deleted, nothing comes out
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);   // deleted at the end: empty closing word

      // Widest pattern and replacement, with the sink holding off meanwhile.
      load_settings(sfr_pkg::LEN_W'(8), 64'h0123_4567_89AB_CDEF,
                    sfr_pkg::LEN_W'(8), 64'hFFEE_DDCC_BBAA_9988, 1'b1);
      hold_request = 1'b1;
      for (k = 0; k < 8; k++)
         send_word(sb.pattern_word[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W], 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hEF, 1'b1);   // short window flushed at the end

      // Pattern length 0 reads as 1, replacement length 15 as 8.
      load_settings(sfr_pkg::LEN_W'(0), 64'h0000_0000_0000_00FF,
                    sfr_pkg::LEN_W'(15), 64'h8040_2010_0804_0201, 1'b1);
      put_reg(CSR_LAST_INDEX, '1);   // unmapped index, registers must not move
      send_word(8'hFF, 1'b1);

      // Rewriting the pattern length mid-string drops what is pending.
      load_settings(sfr_pkg::LEN_W'(3), 64'h0000_0000_0043_4241, sfr_pkg::LEN_W'(0), '0, 1'b1);
      send_word(8'h41, 1'b0);
      send_word(8'h42, 1'b0);
      wait_for_drain();
      put_reg(sfr_pkg::CSR_PATTERN_LENGTH, sfr_pkg::DATA_W'(3));
      send_word(8'h43, 1'b1);   // lone byte flushed, count still zero
      send_word(8'h41, 1'b0);
      send_word(8'h42, 1'b0);
      send_word(8'h43, 1'b1);   // whole match deleted: empty word with count one

      // Random phases: fixed extremes first, then random lengths, some
      // phases leaving the pattern length (and the pending window) alone.
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         calm = (random_items + CALM_ITEMS >= RANDOM_ITEMS);
         rep  = {$urandom, $urandom};
         if ($urandom_range(0, 1)) begin
            pat = {$urandom, $urandom};
         end else begin
            // two-letter alphabet: self-overlapping patterns
            pick_a = sfr_pkg::BYTE_W'($urandom);
            pick_b = sfr_pkg::BYTE_W'($urandom);
            for (k = 0; k < 8; k++)
               pat[sfr_pkg::BYTE_W*k +: sfr_pkg::BYTE_W] =
                  $urandom_range(0, 1) ? pick_a : pick_b;
         end
         case (phase)
            0: begin plen = sfr_pkg::LEN_W'(8); rlen = sfr_pkg::LEN_W'(8); end
            1: begin plen = sfr_pkg::LEN_W'(1); rlen = sfr_pkg::LEN_W'(0); end
            2: begin plen = sfr_pkg::LEN_W'(8); rlen = sfr_pkg::LEN_W'(0); end
            3: begin plen = sfr_pkg::LEN_W'(1); rlen = sfr_pkg::LEN_W'(8); end
            default: begin
               plen = sfr_pkg::LEN_W'($urandom_range(0, 15));
               rlen = sfr_pkg::LEN_W'($urandom_range(0, 15));
            end
         endcase
         load_settings(plen, pat, rlen, rep, (phase < 4) || ($urandom_range(0, 3) != 0));
         if ($urandom_range(0, 3) == 0)
            put_reg(sfr_pkg::CSR_ADDR_W'($urandom_range(sfr_pkg::CSR_REPLACE_LENGTH + 1,
                                                         CSR_LAST_INDEX)),
                    {$urandom, $urandom});
         if (!calm && (phase == 0 || phase == 6)) hold_request = 1'b1;

         strings = $urandom_range(1, 4);
         repeat (strings) begin
            compose_text();
            send_text(1'b1, $urandom_range(0, 1));
            random_items += text_q.size();
         end
         // sometimes leave a string open across the next register change
         if ($urandom_range(0, 2) == 0) begin
            compose_text();
            send_text(1'b0, $urandom_range(0, 1));
            random_items += text_q.size();
         end
         phase++;
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_if.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace_core.sv
tb/sv/tb_stream_find_replace_core.sv
